### design/tlb_pkg.sv
package tlb_pkg;

   localparam int MAX_CHARS_DEFAULT = 256;
   localparam int MAX_LINES_DEFAULT = 64;

   localparam int CODE_W     = 8;
   localparam int ADV_W      = 8;
   localparam int START_W    = 8;
   localparam int LEN_W      = 9;
   localparam int BOX_W      = 10;
   localparam int CSR_DATA_W = 10;

   localparam logic [CODE_W-1:0] CH_CR     = 8'd13;
   localparam logic [CODE_W-1:0] CH_HYPHEN = 8'd45;
   localparam logic [CODE_W-1:0] CH_SPACE  = 8'd32;

   localparam logic [BOX_W-1:0] BOX_WIDTH_RESET = 10'd320;

   typedef enum logic [0:0] {
      CSR_BOX_WIDTH     = 1'b0,
      CSR_RIGHT_JUSTIFY = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_EMIT_RD,
      ST_EMIT_PUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic eval;
      logic push;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic scan_stop;
      logic out_free;
      logic emit_last;
   } status_type;

endpackage

### design/tlb_req_if.sv
interface tlb_req_if;
   logic                       valid;
   logic                       ready;
   logic [tlb_pkg::CODE_W-1:0] char_code;
   logic [tlb_pkg::ADV_W-1:0]  char_advance;
   logic                       last_char;

   modport source (output valid, output char_code, output char_advance, output last_char,
                   input ready);
   modport sink   (input valid, input char_code, input char_advance, input last_char,
                   output ready);
endinterface

### design/tlb_rsp_if.sv
interface tlb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tlb_pkg::START_W-1:0] line_start;
   logic [tlb_pkg::LEN_W-1:0]   line_length;
   logic                        final_line;
   logic                        cut_short;

   modport source (output valid, output line_start, output line_length, output final_line,
                   output cut_short, input ready);
   modport sink   (input valid, input line_start, input line_length, input final_line,
                   input cut_short, output ready);
endinterface

### design/tlb_ctrl.sv
module tlb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last_char,
   output logic                  req_ready,
   input  tlb_pkg::status_type   status,
   output tlb_pkg::cmd_type      cmd
);

   tlb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlb_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tlb_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_char) begin
                  cmd.scan_init = 1'b1;
                  state_in      = tlb_pkg::ST_SCAN_RD;
               end
            end
         end
         tlb_pkg::ST_SCAN_RD: begin
            state_in = tlb_pkg::ST_SCAN_EVAL;
         end
         tlb_pkg::ST_SCAN_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.scan_stop ? tlb_pkg::ST_EMIT_RD : tlb_pkg::ST_SCAN_RD;
         end
         tlb_pkg::ST_EMIT_RD: begin
            state_in = tlb_pkg::ST_EMIT_PUSH;
         end
         tlb_pkg::ST_EMIT_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               if (status.emit_last) begin
                  cmd.clear = 1'b1;
                  state_in  = tlb_pkg::ST_LOAD;
               end else begin
                  state_in = tlb_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = tlb_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

### design/tlb_datapath.sv
module tlb_datapath #(
   parameter int MAX_CHARS = tlb_pkg::MAX_CHARS_DEFAULT,
   parameter int MAX_LINES = tlb_pkg::MAX_LINES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tlb_pkg::cmd_type                  cmd,
   output tlb_pkg::status_type               status,
   input  logic [tlb_pkg::CODE_W-1:0]        req_char_code,
   input  logic [tlb_pkg::ADV_W-1:0]         req_char_advance,
   input  logic                              csr_we,
   input  tlb_pkg::csr_index_type            csr_index,
   input  logic [tlb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tlb_pkg::START_W-1:0]       rsp_line_start,
   output logic [tlb_pkg::LEN_W-1:0]         rsp_line_length,
   output logic                              rsp_final_line,
   output logic                              rsp_cut_short
);

   localparam int ADDR_W  = $clog2(MAX_CHARS);
   localparam int CNT_W   = $clog2(MAX_CHARS + 1);
   localparam int LCNT_W  = $clog2(MAX_LINES + 1);
   localparam int LADR_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int WORD_W  = tlb_pkg::CODE_W + tlb_pkg::ADV_W;
   localparam int LWORD_W = tlb_pkg::START_W + tlb_pkg::LEN_W;
   localparam int WSUM_W  = tlb_pkg::BOX_W + 1;

   logic [tlb_pkg::BOX_W-1:0] box_width_ff;
   logic                      rj_mode_ff;

   logic [CNT_W-1:0]  count_ff;
   logic              ovf_ff;
   logic [WORD_W-1:0] char_mem [MAX_CHARS];
   logic [WORD_W-1:0] rd_cur_ff, rd_nxt_ff;

   logic [CNT_W-1:0]          start_ff, idx_ff, brk_ff;
   logic                      brk_valid_ff;
   logic [tlb_pkg::BOX_W-1:0] w_ff;
   logic [LCNT_W-1:0]         nl_ff, emit_ff;
   logic                      cut_ff;

   logic [LWORD_W-1:0] line_mem [MAX_LINES];
   logic [LWORD_W-1:0] lm_rd_ff;

   logic                       rsp_valid_ff;
   logic [tlb_pkg::START_W-1:0] rsp_start_ff;
   logic [tlb_pkg::LEN_W-1:0]  rsp_len_ff;
   logic                       rsp_final_ff, rsp_cut_ff;

   logic                      full;
   logic [CNT_W-1:0]          idx_nxt, end_abs, len;
   logic [tlb_pkg::CODE_W-1:0] cur_code, nxt_code;
   logic [tlb_pkg::ADV_W-1:0] cur_adv;
   logic [WSUM_W-1:0]         w_sum;
   logic                      over, at_end, next_space, is_space, brk_here;
   logic                      line_done, empty_stop, stop;
   logic [LCNT_W-1:0]         nl_inc;
   logic                      nl_zero, emit_last, out_free;

   assign full     = (count_ff == CNT_W'(MAX_CHARS));
   assign idx_nxt  = idx_ff + CNT_W'(1);
   assign cur_code = rd_cur_ff[WORD_W-1 -: tlb_pkg::CODE_W];
   assign cur_adv  = rd_cur_ff[tlb_pkg::ADV_W-1:0];
   assign nxt_code = rd_nxt_ff[WORD_W-1 -: tlb_pkg::CODE_W];

   always_comb begin
      w_sum      = {1'b0, w_ff} + WSUM_W'(cur_adv);
      over       = (w_sum > {1'b0, box_width_ff});
      at_end     = (idx_nxt == count_ff);
      next_space = !at_end && (nxt_code == tlb_pkg::CH_SPACE);
      is_space   = (cur_code == tlb_pkg::CH_SPACE);
      if (cur_code == tlb_pkg::CH_HYPHEN) begin
         brk_here = 1'b1;
      end else if (rj_mode_ff) begin
         brk_here = next_space && !is_space;
      end else begin
         brk_here = is_space || next_space;
      end
      if (over) begin
         end_abs   = brk_valid_ff ? brk_ff : idx_ff;
         line_done = (end_abs != start_ff);
      end else begin
         end_abs   = idx_nxt;
         line_done = (cur_code == tlb_pkg::CH_CR) || at_end;
      end
      empty_stop = over && (end_abs == start_ff);
      len        = end_abs - start_ff;
      nl_inc     = nl_ff + LCNT_W'(1);
      stop       = empty_stop ||
                   (line_done && ((nl_inc == LCNT_W'(MAX_LINES)) || (end_abs == count_ff)));
   end

   assign nl_zero   = (nl_ff == '0);
   assign emit_last = nl_zero || ((emit_ff + LCNT_W'(1)) == nl_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign status.scan_stop = stop;
   assign status.out_free  = out_free;
   assign status.emit_last = emit_last;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         box_width_ff <= tlb_pkg::BOX_WIDTH_RESET;
         rj_mode_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            tlb_pkg::CSR_BOX_WIDTH:     box_width_ff <= csr_wdata[tlb_pkg::BOX_W-1:0];
            tlb_pkg::CSR_RIGHT_JUSTIFY: rj_mode_ff   <= csr_wdata[0];
         endcase
      end
   end

   // character store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         char_mem[count_ff[ADDR_W-1:0]] <= {req_char_code, req_char_advance};
      end
      rd_cur_ff <= char_mem[idx_ff[ADDR_W-1:0]];
      rd_nxt_ff <= char_mem[idx_nxt[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.clear) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (full) begin
            ovf_ff <= 1'b1;
         end else begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // break scan
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         start_ff     <= '0;
         idx_ff       <= '0;
         w_ff         <= '0;
         brk_valid_ff <= 1'b0;
         nl_ff        <= '0;
      end else if (cmd.eval) begin
         if (line_done) begin
            nl_ff        <= nl_inc;
            start_ff     <= end_abs;
            idx_ff       <= end_abs;
            w_ff         <= '0;
            brk_valid_ff <= 1'b0;
         end else if (!over) begin
            idx_ff <= idx_nxt;
            w_ff   <= w_sum[tlb_pkg::BOX_W-1:0];
            if (brk_here) begin
               brk_ff       <= idx_nxt;
               brk_valid_ff <= 1'b1;
            end
         end
         if (stop) begin
            cut_ff <= (end_abs != count_ff) || ovf_ff;
         end
      end
   end

   // line store
   always_ff @(posedge clock) begin
      if (cmd.eval && line_done) begin
         line_mem[nl_ff[LADR_W-1:0]] <=
            {tlb_pkg::START_W'(start_ff), tlb_pkg::LEN_W'(len)};
      end
      lm_rd_ff <= line_mem[emit_ff[LADR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         emit_ff <= '0;
      end else if (cmd.push) begin
         emit_ff <= emit_ff + LCNT_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_start_ff <= nl_zero ? '0 : lm_rd_ff[LWORD_W-1 -: tlb_pkg::START_W];
         rsp_len_ff   <= nl_zero ? '0 : lm_rd_ff[tlb_pkg::LEN_W-1:0];
         rsp_final_ff <= emit_last;
         rsp_cut_ff   <= cut_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_start  = rsp_start_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_final_line  = rsp_final_ff;
   assign rsp_cut_short   = rsp_cut_ff;

endmodule

### design/text_line_breaker_unit.sv
// channel  | dir | signals
// ---------+-----+------------------------------------------------------------
// req_if   | in  | valid, ready, char_code[7:0], char_advance[7:0], last_char
// rsp_if   | out | valid, ready, line_start[7:0], line_length[8:0], final_line,
//          |     | cut_short
// csr      | in  | csr_we, csr_index[0:0], csr_wdata[9:0]
//
// Loading accepts one beat per cycle; the beat with last_char starts the scan:
// each character visited is read from the character store into a register and
// evaluated; a line that breaks back at a break point rereads from there. Each
// result is read from the line store and pushed to the output register. Reset
// is synchronous; it empties the string and clears the overflow flag, the
// right-justify flag and rsp_if valid. A stalled rsp_if holds the emit sequence;
// req_if is closed from the last beat until the final result is in the output register.
module text_line_breaker_unit #(
   parameter int MAX_CHARS = tlb_pkg::MAX_CHARS_DEFAULT,
   parameter int MAX_LINES = tlb_pkg::MAX_LINES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   tlb_req_if.sink                        req_if,
   tlb_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  tlb_pkg::csr_index_type         csr_index,
   input  logic [tlb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tlb_pkg::cmd_type    cmd;
   tlb_pkg::status_type status;

   tlb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_last_char (req_if.last_char),
      .req_ready     (req_if.ready),
      .status        (status),
      .cmd           (cmd)
   );

   tlb_datapath #(
      .MAX_CHARS (MAX_CHARS),
      .MAX_LINES (MAX_LINES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_char_code    (req_if.char_code),
      .req_char_advance (req_if.char_advance),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_line_start   (rsp_if.line_start),
      .rsp_line_length  (rsp_if.line_length),
      .rsp_final_line   (rsp_if.final_line),
      .rsp_cut_short    (rsp_if.cut_short)
   );

endmodule

### design/tlb_checker.sv
module tlb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last_char,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tlb_pkg::LEN_W-1:0]   rsp_line_length,
   input logic                        rsp_final_line
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_length == '0) |-> rsp_final_line)
      else $error("empty line that is not the only result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_final_line |=> !rsp_valid)
      else $error("result beat after final line");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_char |=> !req_ready)
      else $error("input open during break scan");

endmodule

bind text_line_breaker_unit tlb_checker u_tlb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_last_char   (req_if.last_char),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_line_length (rsp_if.line_length),
   .rsp_final_line  (rsp_if.final_line)
);
